// ===== rtl/core/lzf_pkg.sv =====
// Package for the LZF decompressor: widths, status and phase codes, FSM states.
// No dependencies; used by the channel interfaces and by lzf_decompressor.
package lzf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 24;
    localparam int POS_W      = 24;
    localparam int HIST_DEPTH = 8192;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int DIST_W     = HIST_AW + 1;
    localparam int LIT_W      = 6;
    localparam int REF_W      = 9;
    localparam int REM_W      = REF_W + 1;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int DATA_W     = LANES * BYTE_W;
    localparam int COUNT_W    = LANE_W + 1;
    localparam int STATUS_W   = 2;

    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [BYTE_W-1:0] LIT_LIMIT = 8'd32;
    localparam logic [2:0]        EXT_CODE  = 3'd7;
    localparam logic [LEN_W-1:0]  LEN_RESET = 24'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN    = 2'd0,
        ST_DONE   = 2'd1,
        ST_OVER   = 2'd2,
        ST_BEFORE = 2'd3
    } run_status_t;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_EXT  = 2'd2,
        PH_DIST = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CHECK = 2'd1,
        S_READ  = 2'd2,
        S_WRITE = 2'd3
    } state_t;

endpackage

// ===== rtl/core/lzf_if.sv =====
// Valid/ready channel interfaces for the LZF decompressor input and output words.
// Depends on lzf_pkg for field widths.
interface lzf_in_if;
    import lzf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] comp_byte;
    logic              start_block;

    modport source (output valid, output comp_byte, output start_block, input ready);
    modport sink   (input valid, input comp_byte, input start_block, output ready);
endinterface

interface lzf_out_if;
    import lzf_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   out_data;
    logic [COUNT_W-1:0]  out_count;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output out_data, output out_count, output status,
                    output last, input ready);
    modport sink   (input valid, input out_data, input out_count, input status,
                    input last, output ready);
endinterface

// ===== rtl/core/lzf_decompressor.sv =====
// LZF decompressor top level: token decoder, 8 KiB history and byte-copy sequencer.
// Depends on lzf_pkg and the lzf_in_if / lzf_out_if channel interfaces.
//
//   channel   dir  handshake    payload
//   in_chan   in   valid/ready  comp_byte[7:0], start_block
//   out_chan  out  valid/ready  out_data[63:0], out_count[3:0], status[1:0], last
//   cfg       in   cfg_we       cfg_data[23:0] -> out_length
//
// Control, extension, literal and ignored bytes produce one output word each.
// Back reference: the history is read then written once per copied byte, and
// copied bytes are packed eight to an output word.
// Reset clears decoder state and sets out_length to 1; the history is not cleared.
// A full output register holds the sequencer and drops in_chan.ready.
module lzf_decompressor
(
    input  logic                      clk,
    input  logic                      rst_n,
    lzf_in_if.sink                    in_chan,
    lzf_out_if.source                 out_chan,
    input  logic                      cfg_we,
    input  logic [lzf_pkg::LEN_W-1:0] cfg_data
);
    import lzf_pkg::*;

    state_t              state_reg,     state_next;
    phase_t              phase_reg,     phase_next;
    run_status_t         status_reg,    status_next;
    logic [LIT_W-1:0]    lit_left_reg,  lit_left_next;
    logic [REF_W-1:0]    ref_len_reg,   ref_len_next;
    logic [4:0]          dist_hi_reg,   dist_hi_next;
    logic [POS_W-1:0]    pos_reg,       pos_next;
    logic [LEN_W-1:0]    out_length_reg, out_length_next;
    logic [REM_W-1:0]    rem_reg,       rem_next;
    logic [LANE_W-1:0]   cnt_reg,       cnt_next;
    logic                out_valid_reg, out_valid_next;

    logic [DIST_W-1:0]   dist_reg,      dist_next;
    logic [HIST_AW-1:0]  src_reg,       src_next;
    logic [DATA_W-1:0]   word_reg,      word_next;
    logic [BYTE_W-1:0]   rdata_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [BYTE_W-1:0]   history [HIST_DEPTH];

    logic                out_free;
    logic                in_ready;
    logic                accept;
    logic                hist_we;
    logic                hist_re;
    logic [HIST_AW-1:0]  hist_waddr;
    logic [BYTE_W-1:0]   hist_wdata;
    logic                load_out;
    logic [DATA_W-1:0]   res_data;
    logic [COUNT_W-1:0]  res_count;
    logic                res_last;

    assign out_free = !out_valid_reg || out_chan.ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_chan.valid && in_ready;

    assign in_chan.ready      = in_ready;
    assign out_chan.valid     = out_valid_reg;
    assign out_chan.out_data  = out_data_reg;
    assign out_chan.out_count = out_count_reg;
    assign out_chan.status    = out_status_reg;
    assign out_chan.last      = out_last_reg;

    always_comb
    begin
        logic [BYTE_W-1:0]  b;
        phase_t             ph_eff;
        run_status_t        st_eff;
        logic [LIT_W-1:0]   lit_eff;
        logic [LIT_W-1:0]   lit_dec;
        logic [REF_W-1:0]   ref_eff;
        logic [4:0]         dist_hi_eff;
        logic [POS_W-1:0]   pos_eff;
        logic [POS_W-1:0]   pos_inc;
        logic [POS_W:0]     end_sum;
        logic [DATA_W-1:0]  word_ins;
        logic               emit;

        b           = in_chan.comp_byte;
        ph_eff      = in_chan.start_block ? PH_CTRL : phase_reg;
        st_eff      = in_chan.start_block ? ST_RUN : status_reg;
        lit_eff     = in_chan.start_block ? '0 : lit_left_reg;
        ref_eff     = in_chan.start_block ? '0 : ref_len_reg;
        dist_hi_eff = in_chan.start_block ? '0 : dist_hi_reg;
        pos_eff     = in_chan.start_block ? '0 : pos_reg;
        lit_dec     = '0;
        pos_inc     = '0;
        end_sum     = '0;
        emit        = 1'b0;
        word_ins    = word_reg;
        word_ins[{cnt_reg, 3'b000} +: BYTE_W] = rdata_reg;

        state_next      = state_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        lit_left_next   = lit_left_reg;
        ref_len_next    = ref_len_reg;
        dist_hi_next    = dist_hi_reg;
        pos_next        = pos_reg;
        out_length_next = cfg_we ? cfg_data : out_length_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        dist_next       = dist_reg;
        src_next        = src_reg;
        word_next       = word_reg;

        hist_we    = 1'b0;
        hist_re    = 1'b0;
        hist_waddr = pos_reg[HIST_AW-1:0];
        hist_wdata = rdata_reg;
        load_out   = 1'b0;
        res_data   = '0;
        res_count  = '0;
        res_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out      = 1'b1;
                    phase_next    = ph_eff;
                    status_next   = st_eff;
                    lit_left_next = lit_eff;
                    ref_len_next  = ref_eff;
                    dist_hi_next  = dist_hi_eff;
                    pos_next      = pos_eff;
                    if (st_eff == ST_RUN)
                    begin
                        unique case (ph_eff)
                            PH_CTRL:
                            begin
                                if (b < LIT_LIMIT)
                                begin
                                    lit_left_next = {1'b0, b[4:0]} + LIT_W'(1);
                                    phase_next    = PH_LIT;
                                end
                                else
                                begin
                                    ref_len_next = REF_W'(b[7:5]);
                                    dist_hi_next = b[4:0];
                                    phase_next   = (b[7:5] == EXT_CODE) ? PH_EXT : PH_DIST;
                                end
                            end
                            PH_LIT:
                            begin
                                hist_we    = 1'b1;
                                hist_waddr = pos_eff[HIST_AW-1:0];
                                hist_wdata = b;
                                pos_inc    = (pos_eff == POS_MAX) ? pos_eff
                                                                  : pos_eff + POS_W'(1);
                                pos_next   = pos_inc;
                                lit_dec    = (lit_eff != '0) ? lit_eff - LIT_W'(1) : '0;
                                lit_left_next = lit_dec;
                                if (lit_dec == '0)
                                begin
                                    phase_next = PH_CTRL;
                                    if (pos_inc >= out_length_reg)
                                        status_next = ST_DONE;
                                end
                                res_data  = DATA_W'(b);
                                res_count = COUNT_W'(1);
                            end
                            PH_EXT:
                            begin
                                ref_len_next = ref_eff + REF_W'(b);
                                phase_next   = PH_DIST;
                            end
                            PH_DIST:
                            begin
                                phase_next = PH_CTRL;
                                dist_next  = DIST_W'({dist_hi_eff, b}) + DIST_W'(1);
                                rem_next   = REM_W'(ref_eff) + REM_W'(2);
                                load_out   = 1'b0;
                                state_next = S_CHECK;
                            end
                            default:
                            begin
                                phase_next = PH_CTRL;
                            end
                        endcase
                    end
                end
            end
            S_CHECK:
            begin
                end_sum = {1'b0, pos_reg} + (POS_W + 1)'(rem_reg);
                if (end_sum >= {1'b0, out_length_reg})
                begin
                    if (out_free)
                    begin
                        status_next = ST_OVER;
                        load_out    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (POS_W'(dist_reg) > pos_reg)
                begin
                    if (out_free)
                    begin
                        status_next = ST_BEFORE;
                        load_out    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    src_next   = pos_reg[HIST_AW-1:0] - dist_reg[HIST_AW-1:0];
                    word_next  = '0;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                hist_re    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                emit = (cnt_reg == LANE_W'(LANES - 1)) || (rem_reg == REM_W'(1));
                if (!emit || out_free)
                begin
                    hist_we  = 1'b1;
                    pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                    pos_next = pos_inc;
                    src_next = src_reg + HIST_AW'(1);
                    rem_next = rem_reg - REM_W'(1);
                    if (emit)
                    begin
                        load_out  = 1'b1;
                        res_data  = word_ins;
                        res_count = COUNT_W'(cnt_reg) + COUNT_W'(1);
                        word_next = '0;
                        cnt_next  = '0;
                        if (rem_reg == REM_W'(1))
                        begin
                            phase_next = PH_CTRL;
                            if (pos_inc >= out_length_reg)
                                status_next = ST_DONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            res_last   = 1'b0;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        word_next  = word_ins;
                        cnt_next   = cnt_reg + LANE_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_CTRL;
            status_reg     <= ST_RUN;
            lit_left_reg   <= '0;
            ref_len_reg    <= '0;
            dist_hi_reg    <= '0;
            pos_reg        <= '0;
            out_length_reg <= LEN_RESET;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            lit_left_reg   <= lit_left_next;
            ref_len_reg    <= ref_len_next;
            dist_hi_reg    <= dist_hi_next;
            pos_reg        <= pos_next;
            out_length_reg <= out_length_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        src_reg  <= src_next;
        word_reg <= word_next;
        if (load_out)
        begin
            out_data_reg   <= res_data;
            out_count_reg  <= res_count;
            out_status_reg <= status_next;
            out_last_reg   <= res_last;
        end
    end

    // history: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_we)
            history[hist_waddr] <= hist_wdata;
        if (hist_re)
            rdata_reg <= history[src_reg];
    end

    // a pending word is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_valid_reg) |-> out_chan.ready)
        else $error("output word overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ($past(state_reg) == S_READ || $past(state_reg) == S_WRITE))
        else $error("copy write without a preceding history read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_WRITE) |->
            (status_reg == ST_RUN && rem_reg != '0))
        else $error("copy running with no bytes left or after block end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> $past(accept))
        else $error("reference check entered without a distance byte");

endmodule
